// ----- src/rrts_pkg.sv -----
// rrts_pkg: shared types, codes and the control store of the round-robin task scheduler
// depends on nothing; used by round_robin_task_scheduler_top
`default_nettype none

package rrts_pkg;

  // task slot states
  localparam logic [1:0] ST_EMPTY   = 2'd0;
  localparam logic [1:0] ST_READY   = 2'd1;
  localparam logic [1:0] ST_RUNNING = 2'd2;
  localparam logic [1:0] ST_DEAD    = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_FULL       = 2'd1;
  localparam logic [1:0] STAT_UNKNOWN    = 2'd2;
  localparam logic [1:0] STAT_NONE_READY = 2'd3;

  // action codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_ADD   = 2'd1;
  localparam logic [1:0] ACT_KILL  = 2'd2;
  localparam logic [1:0] ACT_QUERY = 2'd3;

  typedef logic [4:0] step_t;
  typedef logic [3:0] cond_t;
  typedef logic [2:0] asel_t;
  typedef logic [1:0] wsel_t;
  typedef logic [2:0] esel_t;

  // sequencing conditions
  localparam cond_t C_NEXT     = 4'd0;
  localparam cond_t C_ALWAYS   = 4'd1;
  localparam cond_t C_DISPATCH = 4'd2;
  localparam cond_t C_HIT      = 4'd3;
  localparam cond_t C_NOT_RUN  = 4'd4;
  localparam cond_t C_MORE     = 4'd5;
  localparam cond_t C_FULL     = 4'd6;
  localparam cond_t C_OOR      = 4'd7;
  localparam cond_t C_EMPTY    = 4'd8;

  // table address sources
  localparam asel_t A_CUR      = 3'd0;
  localparam asel_t A_SCAN     = 3'd1;
  localparam asel_t A_SCAN_NXT = 3'd2;
  localparam asel_t A_ID       = 3'd3;
  localparam asel_t A_FREE     = 3'd4;

  // table write data
  localparam wsel_t W_NONE    = 2'd0;
  localparam wsel_t W_READY   = 2'd1;
  localparam wsel_t W_RUNNING = 2'd2;
  localparam wsel_t W_DEAD    = 2'd3;

  // result forms
  localparam esel_t E_NONE  = 3'd0;
  localparam esel_t E_RUN   = 3'd1;
  localparam esel_t E_IDLE  = 3'd2;
  localparam esel_t E_ADD   = 3'd3;
  localparam esel_t E_FULL  = 3'd4;
  localparam esel_t E_KILL  = 3'd5;
  localparam esel_t E_QUERY = 3'd6;
  localparam esel_t E_UNK   = 3'd7;

  typedef struct packed {
    cond_t cond;
    step_t target;
    asel_t asel;
    logic  rd;
    wsel_t wsel;
    esel_t emit;
    logic  scan_init;
    logic  scan_step;
    logic  set_cur;
    logic  inc_free;
  } ctl_t;

  // program steps
  localparam step_t S_IDLE  = 5'd0;
  localparam step_t S_T0    = 5'd1;
  localparam step_t S_T1    = 5'd2;
  localparam step_t S_T2    = 5'd3;
  localparam step_t S_T3    = 5'd4;
  localparam step_t S_T4    = 5'd5;
  localparam step_t S_T5    = 5'd6;
  localparam step_t S_T6    = 5'd7;
  localparam step_t S_THIT  = 5'd8;
  localparam step_t S_A0    = 5'd9;
  localparam step_t S_A1    = 5'd10;
  localparam step_t S_AFULL = 5'd11;
  localparam step_t S_K0    = 5'd12;
  localparam step_t S_K1    = 5'd13;
  localparam step_t S_K2    = 5'd14;
  localparam step_t S_Q0    = 5'd15;
  localparam step_t S_Q1    = 5'd16;
  localparam step_t S_Q2    = 5'd17;
  localparam step_t S_UNK   = 5'd18;

  // control store
  function automatic ctl_t ucode(input step_t step);
    ctl_t c;
    c = '0;
    case (step)
      S_IDLE: begin
        c.cond = C_DISPATCH;
      end
      S_T0: begin
        c.asel = A_CUR; c.rd = 1'b1; c.scan_init = 1'b1;
      end
      S_T1: begin
        c.cond = C_NOT_RUN; c.target = S_T3;
      end
      S_T2: begin
        c.asel = A_CUR; c.wsel = W_READY;
      end
      S_T3: begin
        c.asel = A_SCAN_NXT; c.rd = 1'b1; c.scan_step = 1'b1;
      end
      S_T4: begin
        c.cond = C_HIT; c.target = S_THIT;
      end
      S_T5: begin
        c.cond = C_MORE; c.target = S_T3;
      end
      S_T6: begin
        c.emit = E_IDLE; c.cond = C_ALWAYS; c.target = S_IDLE;
      end
      S_THIT: begin
        c.asel = A_SCAN; c.wsel = W_RUNNING; c.set_cur = 1'b1;
        c.emit = E_RUN; c.cond = C_ALWAYS; c.target = S_IDLE;
      end
      S_A0: begin
        c.cond = C_FULL; c.target = S_AFULL;
      end
      S_A1: begin
        c.asel = A_FREE; c.wsel = W_READY; c.inc_free = 1'b1;
        c.emit = E_ADD; c.cond = C_ALWAYS; c.target = S_IDLE;
      end
      S_AFULL: begin
        c.emit = E_FULL; c.cond = C_ALWAYS; c.target = S_IDLE;
      end
      S_K0: begin
        c.asel = A_ID; c.rd = 1'b1; c.cond = C_OOR; c.target = S_UNK;
      end
      S_K1: begin
        c.cond = C_EMPTY; c.target = S_UNK;
      end
      S_K2: begin
        c.asel = A_ID; c.wsel = W_DEAD; c.emit = E_KILL;
        c.cond = C_ALWAYS; c.target = S_IDLE;
      end
      S_Q0: begin
        c.asel = A_ID; c.rd = 1'b1; c.cond = C_OOR; c.target = S_UNK;
      end
      S_Q1: begin
        c.cond = C_EMPTY; c.target = S_UNK;
      end
      S_Q2: begin
        c.emit = E_QUERY; c.cond = C_ALWAYS; c.target = S_IDLE;
      end
      S_UNK: begin
        c.emit = E_UNK; c.cond = C_ALWAYS; c.target = S_IDLE;
      end
      default: begin
        c.cond = C_ALWAYS; c.target = S_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- src/round_robin_task_scheduler_top.sv -----
// round_robin_task_scheduler_top: task table, step sequencer and result register
// depends on rrts_pkg (codes, control word type, control store)
`default_nettype none

// Round-robin task scheduler. A table of MAX_TASKS two-bit slot states (empty, ready,
// running, dead) sits in a small memory with one registered read port; a flip-flop
// valid bit per slot makes unwritten slots read as their reset value (slot 0 ready,
// the rest empty), so no clearing pass is needed after reset. One item is worked on
// at a time and in_stall stays high until the program returns to its idle step.
// Control is a short program in rrts_pkg::ucode stepped by a program counter; each
// table read goes through the registered read port. A tick first puts a running
// current task back to ready, then runs the three-step scan loop once per slot,
// from the slot after the current one up to and including the first ready one, or
// over every slot, ending on the current one, when none is ready. Each beat yields
// exactly one result beat; the result sits in an output register and the program
// holds at its emit step while that register is still occupied and stalled.
module round_robin_task_scheduler_top #(
  parameter int MAX_TASKS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_action,
  input  wire logic [3:0] in_task_id,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [3:0]      out_result_id,
  output logic [1:0]      out_task_state,
  output logic [1:0]      out_status
);

  // slot index, id counter and common compare widths
  localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int FW = $clog2(MAX_TASKS + 1);
  localparam int IW = (FW > 4) ? FW : 4;
  localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_TASKS - 1);
  localparam logic [FW-1:0] MAX_CNT   = FW'(MAX_TASKS);
  localparam logic [IW-1:0] MAX_ID    = IW'(MAX_TASKS);

  // sequencer
  rrts_pkg::step_t pc_r, pc_nxt;
  rrts_pkg::ctl_t  ctl;

  // datapath registers
  logic [SW-1:0] cur_r;
  logic [SW-1:0] scan_r;
  logic [FW-1:0] cnt_r;
  logic [FW-1:0] free_r;
  logic [3:0]    id_r;
  logic [1:0]    rd_r;

  // task table and its valid bits
  logic [1:0]           mem [MAX_TASKS];
  logic [MAX_TASKS-1:0] vld_r;

  // result register
  logic       out_valid_r;
  logic [3:0] res_id_r;
  logic [1:0] res_state_r;
  logic [1:0] res_status_r;

  logic          adv;
  logic          cond_hit;
  logic [SW-1:0] scan_nxt;
  logic [SW-1:0] addr;
  logic          mem_we;
  logic          mem_re;
  logic [1:0]    wdata;
  logic [IW-1:0] id_ext;
  logic [IW-1:0] cur_ext;
  logic [IW-1:0] scan_ext;
  logic [IW-1:0] free_ext;
  rrts_pkg::step_t disp_step;

  assign ctl = rrts_pkg::ucode(pc_r);

  // busy whenever the program is away from its idle step
  assign in_stall = (pc_r != rrts_pkg::S_IDLE);

  // an emit step may only proceed when the result register can take the beat
  assign adv = (ctl.emit == rrts_pkg::E_NONE) || !out_valid_r || !out_stall;

  assign id_ext   = IW'(id_r);
  assign cur_ext  = IW'(cur_r);
  assign scan_ext = IW'(scan_r);
  assign free_ext = IW'(free_r);

  // cyclic successor of the scan pointer
  assign scan_nxt = (scan_r == LAST_SLOT) ? '0 : scan_r + SW'(1);

  // action decode for the idle step
  always_comb begin
    case (in_action)
      rrts_pkg::ACT_TICK:  disp_step = rrts_pkg::S_T0;
      rrts_pkg::ACT_ADD:   disp_step = rrts_pkg::S_A0;
      rrts_pkg::ACT_KILL:  disp_step = rrts_pkg::S_K0;
      default:             disp_step = rrts_pkg::S_Q0;
    endcase
  end

  // branch condition
  always_comb begin
    case (ctl.cond)
      rrts_pkg::C_HIT:     cond_hit = (rd_r == rrts_pkg::ST_READY);
      rrts_pkg::C_NOT_RUN: cond_hit = (rd_r != rrts_pkg::ST_RUNNING);
      rrts_pkg::C_MORE:    cond_hit = (cnt_r != MAX_CNT);
      rrts_pkg::C_FULL:    cond_hit = (free_r >= MAX_CNT);
      rrts_pkg::C_OOR:     cond_hit = (id_ext >= MAX_ID);
      rrts_pkg::C_EMPTY:   cond_hit = (rd_r == rrts_pkg::ST_EMPTY);
      default:             cond_hit = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    case (ctl.cond)
      rrts_pkg::C_NEXT:     pc_nxt = pc_r + 5'd1;
      rrts_pkg::C_ALWAYS:   pc_nxt = ctl.target;
      rrts_pkg::C_DISPATCH: pc_nxt = in_valid ? disp_step : pc_r;
      default:              pc_nxt = cond_hit ? ctl.target : pc_r + 5'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= rrts_pkg::S_IDLE;
    end else if (adv) begin
      pc_r <= pc_nxt;
    end
  end

  // latch the accepted beat
  always_ff @(posedge clk) begin
    if (pc_r == rrts_pkg::S_IDLE && in_valid) begin
      id_r <= in_task_id;
    end
  end

  // table address and write data
  always_comb begin
    case (ctl.asel)
      rrts_pkg::A_CUR:      addr = cur_r;
      rrts_pkg::A_SCAN:     addr = scan_r;
      rrts_pkg::A_SCAN_NXT: addr = scan_nxt;
      rrts_pkg::A_ID:       addr = id_ext[SW-1:0];
      rrts_pkg::A_FREE:     addr = free_ext[SW-1:0];
      default:              addr = cur_r;
    endcase
  end

  always_comb begin
    case (ctl.wsel)
      rrts_pkg::W_READY:   wdata = rrts_pkg::ST_READY;
      rrts_pkg::W_RUNNING: wdata = rrts_pkg::ST_RUNNING;
      default:             wdata = rrts_pkg::ST_DEAD;
    endcase
  end

  assign mem_we = adv && (ctl.wsel != rrts_pkg::W_NONE);
  assign mem_re = adv && ctl.rd;

  // task table: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= wdata;
    end
    if (mem_re) begin
      if (vld_r[addr]) begin
        rd_r <= mem[addr];
      end else begin
        // never-written slot reads as its reset value
        rd_r <= (addr == '0) ? rrts_pkg::ST_READY : rrts_pkg::ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[addr] <= 1'b1;
    end
  end

  // current slot, id counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      free_r <= FW'(1);
    end else if (adv) begin
      if (ctl.set_cur) begin
        cur_r <= scan_r;
      end
      if (ctl.inc_free) begin
        free_r <= free_r + FW'(1);
      end
    end
  end

  // scan pointer and slot count of the tick loop
  always_ff @(posedge clk) begin
    if (adv) begin
      if (ctl.scan_init) begin
        scan_r <= cur_r;
        cnt_r  <= '0;
      end else if (ctl.scan_step) begin
        scan_r <= scan_nxt;
        cnt_r  <= cnt_r + FW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && ctl.emit != rrts_pkg::E_NONE) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl.emit != rrts_pkg::E_NONE) begin
      case (ctl.emit)
        rrts_pkg::E_RUN: begin
          res_id_r     <= scan_ext[3:0];
          res_state_r  <= rrts_pkg::ST_RUNNING;
          res_status_r <= rrts_pkg::STAT_OK;
        end
        rrts_pkg::E_IDLE: begin
          // no ready task: current task stays, report its state
          res_id_r     <= cur_ext[3:0];
          res_state_r  <= rd_r;
          res_status_r <= rrts_pkg::STAT_NONE_READY;
        end
        rrts_pkg::E_ADD: begin
          res_id_r     <= free_ext[3:0];
          res_state_r  <= rrts_pkg::ST_READY;
          res_status_r <= rrts_pkg::STAT_OK;
        end
        rrts_pkg::E_FULL: begin
          res_id_r     <= 4'd0;
          res_state_r  <= rrts_pkg::ST_EMPTY;
          res_status_r <= rrts_pkg::STAT_FULL;
        end
        rrts_pkg::E_KILL: begin
          res_id_r     <= id_r;
          res_state_r  <= rrts_pkg::ST_DEAD;
          res_status_r <= rrts_pkg::STAT_OK;
        end
        rrts_pkg::E_QUERY: begin
          res_id_r     <= id_r;
          res_state_r  <= rd_r;
          res_status_r <= rrts_pkg::STAT_OK;
        end
        default: begin
          // unknown id on kill or query
          res_id_r     <= id_r;
          res_state_r  <= rrts_pkg::ST_EMPTY;
          res_status_r <= rrts_pkg::STAT_UNKNOWN;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_result_id  = res_id_r;
  assign out_task_state = res_state_r;
  assign out_status     = res_status_r;

endmodule

`default_nettype wire

// ----- sim/round_robin_task_scheduler_top_tb.sv -----
// round_robin_task_scheduler_top_tb: self-checking bench for the round-robin task scheduler
// drives tick, add, kill and query beats, predicts every result beat and compares in order
// depends on rrts_pkg and round_robin_task_scheduler_top
`default_nettype none

module round_robin_task_scheduler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_TASKS   = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  // worst tick: full scan with no ready slot, plus some slack
  localparam int TAIL_CYCLES = 3 * MAX_TASKS + 16;

  // one result beat as the block reports it
  typedef struct packed {
    logic [3:0] id;
    logic [1:0] state;
    logic [1:0] status;
  } sched_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_action = rrts_pkg::ACT_TICK;
  logic [3:0] in_task_id = 4'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] out_result_id;
  logic [1:0] out_task_state;
  logic [1:0] out_status;

  // scheduler state as the bench predicts it
  logic [1:0] slot_tbl [MAX_TASKS];
  logic [3:0] cur_slot;
  logic [4:0] free_id;

  // predicted result beats, oldest first
  sched_result_t want_q[$];

  int err_cnt = 0;
  int burst_left = 0;
  int cycle_cnt = 0;

  round_robin_task_scheduler_top #(
    .MAX_TASKS(MAX_TASKS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_task_id    (in_task_id),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_result_id (out_result_id),
    .out_task_state(out_task_state),
    .out_status    (out_status)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run guard: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $realtime, cycle_cnt);
      $display("round_robin_task_scheduler_top_tb NOT OK");
      $finish;
    end
  end

  // predicts one beat and advances the predicted state
  function automatic sched_result_t schedule_step(input logic [1:0] act,
                                                  input logic [3:0] tid);
    sched_result_t r;
    logic [3:0]    s;
    logic          hit;
    hit = 1'b0;
    case (act)
      rrts_pkg::ACT_TICK: begin
        // running current task goes back to ready before the scan
        if (slot_tbl[cur_slot] == rrts_pkg::ST_RUNNING)
          slot_tbl[cur_slot] = rrts_pkg::ST_READY;
        // answer if nothing is ready: current slot stays, with its state
        r = '{cur_slot, slot_tbl[cur_slot], rrts_pkg::STAT_NONE_READY};
        // scan starts after current and ends on current itself
        for (int i = 1; i <= MAX_TASKS; i++) begin
          s = 4'((int'(cur_slot) + i) % MAX_TASKS);
          if (!hit && slot_tbl[s] == rrts_pkg::ST_READY) begin
            hit         = 1'b1;
            slot_tbl[s] = rrts_pkg::ST_RUNNING;
            cur_slot    = s;
            r           = '{s, rrts_pkg::ST_RUNNING, rrts_pkg::STAT_OK};
          end
        end
      end
      rrts_pkg::ACT_ADD: begin
        if (free_id >= MAX_TASKS) begin
          r = '{4'd0, rrts_pkg::ST_EMPTY, rrts_pkg::STAT_FULL};
        end else begin
          slot_tbl[free_id[3:0]] = rrts_pkg::ST_READY;
          r = '{free_id[3:0], rrts_pkg::ST_READY, rrts_pkg::STAT_OK};
          free_id++;
        end
      end
      rrts_pkg::ACT_KILL: begin
        if (slot_tbl[tid] == rrts_pkg::ST_EMPTY) begin
          r = '{tid, rrts_pkg::ST_EMPTY, rrts_pkg::STAT_UNKNOWN};
        end else begin
          // a dead task stays dead and still answers ok
          slot_tbl[tid] = rrts_pkg::ST_DEAD;
          r = '{tid, rrts_pkg::ST_DEAD, rrts_pkg::STAT_OK};
        end
      end
      default: begin
        if (slot_tbl[tid] == rrts_pkg::ST_EMPTY)
          r = '{tid, rrts_pkg::ST_EMPTY, rrts_pkg::STAT_UNKNOWN};
        else r = '{tid, slot_tbl[tid], rrts_pkg::STAT_OK};
      end
    endcase
    return r;
  endfunction

  // sends one beat; the sender works in bursts with idle gaps between them
  task automatic send_beat(input logic [1:0] act, input logic [3:0] tid);
    int gap;
    if (burst_left == 0) begin
      // some bursts follow straight on, so back-to-back beats occur too
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid   = 1'b1;
    in_action  = act;
    in_task_id = tid;
    do @(posedge clk); while (in_stall);
    want_q.push_back(schedule_step(act, tid));
  endtask

  // drops valid and waits for every predicted beat to come out
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (want_q.size() != 0) @(posedge clk);
  endtask

  // result side stalls on its own pattern: free-running stretches, light and
  // heavy random stalls, and long held stalls
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall = 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 300);
      end
      mode_left--;
      case (stall_mode)
        0: out_stall = 1'b0;
        1: out_stall = ($urandom_range(0, 3) == 0);
        2: out_stall = ($urandom_range(0, 1) == 1);
        default: begin
          if (hold_left == 0) begin
            out_stall = ~out_stall;
            hold_left = $urandom_range(1, 10);
          end
          hold_left--;
        end
      endcase
    end
  end

  // every accepted result beat is matched against the oldest prediction
  always @(posedge clk) begin : check_results
    sched_result_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (want_q.size() == 0) begin
        $display("%0t: result beat with nothing expected: id %0d state %0d status %0d",
                 $realtime, out_result_id, out_task_state, out_status);
        err_cnt++;
      end else begin
        due = want_q.pop_front();
        if (out_result_id !== due.id) begin
          $display("%0t: result_id expected %0d actual %0d",
                   $realtime, due.id, out_result_id);
          err_cnt++;
        end
        if (out_task_state !== due.state) begin
          $display("%0t: task_state expected %0d actual %0d",
                   $realtime, due.state, out_task_state);
          err_cnt++;
        end
        if (out_status !== due.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $realtime, due.status, out_status);
          err_cnt++;
        end
      end
    end
  end

  // slot 0 alone: wrap-around onto itself, kill of the current task,
  // double kill, then a tick that finds nothing ready
  task automatic test_lone_task();
    send_beat(rrts_pkg::ACT_QUERY, 4'd0);
    send_beat(rrts_pkg::ACT_QUERY, 4'd1);
    send_beat(rrts_pkg::ACT_QUERY, 4'd15);
    send_beat(rrts_pkg::ACT_TICK, 4'd15);
    send_beat(rrts_pkg::ACT_TICK, 4'd0);
    send_beat(rrts_pkg::ACT_KILL, 4'd1);
    send_beat(rrts_pkg::ACT_KILL, 4'd0);
    send_beat(rrts_pkg::ACT_KILL, 4'd0);
    send_beat(rrts_pkg::ACT_TICK, 4'd9);
    send_beat(rrts_pkg::ACT_QUERY, 4'd0);
  endtask

  // a few tasks: rotation, skipping dead slots, killing the running task
  task automatic test_rotation();
    repeat (4) send_beat(rrts_pkg::ACT_ADD, 4'($urandom_range(0, 15)));
    send_beat(rrts_pkg::ACT_TICK, 4'd0);
    send_beat(rrts_pkg::ACT_TICK, 4'd15);
    send_beat(rrts_pkg::ACT_KILL, 4'd3);
    send_beat(rrts_pkg::ACT_TICK, 4'd3);
    send_beat(rrts_pkg::ACT_KILL, 4'd4);
    send_beat(rrts_pkg::ACT_TICK, 4'd4);
    send_beat(rrts_pkg::ACT_QUERY, 4'd4);
    send_beat(rrts_pkg::ACT_QUERY, 4'd1);
    send_beat(rrts_pkg::ACT_QUERY, 4'd2);
  endtask

  // mixed traffic; kills of live tasks are held back once few remain so the
  // scan keeps finding work
  task automatic test_random_traffic(input int n_beats);
    logic [1:0] act;
    logic [3:0] tid;
    int         pick;
    int         live;
    for (int k = 0; k < n_beats; k++) begin
      pick = $urandom_range(0, 99);
      tid  = 4'($urandom_range(0, 15));
      if (pick < 40) act = rrts_pkg::ACT_TICK;
      else if (pick < 52) act = rrts_pkg::ACT_ADD;
      else if (pick < 72) act = rrts_pkg::ACT_KILL;
      else act = rrts_pkg::ACT_QUERY;
      live = 0;
      foreach (slot_tbl[j])
        if (slot_tbl[j] == rrts_pkg::ST_READY || slot_tbl[j] == rrts_pkg::ST_RUNNING)
          live++;
      if (act == rrts_pkg::ACT_KILL && live <= 3 &&
          (slot_tbl[tid] == rrts_pkg::ST_READY || slot_tbl[tid] == rrts_pkg::ST_RUNNING))
        act = rrts_pkg::ACT_QUERY;
      send_beat(act, tid);
    end
  endtask

  // sender holds off until the block has delivered everything, then resumes
  task automatic test_drain_pause();
    test_random_traffic(12);
    wait_drained();
    test_random_traffic(12);
  endtask

  // use up the remaining ids, then adds must report a full table
  task automatic test_table_full();
    while (free_id < MAX_TASKS) send_beat(rrts_pkg::ACT_ADD, 4'($urandom_range(0, 15)));
    send_beat(rrts_pkg::ACT_ADD, 4'd15);
    send_beat(rrts_pkg::ACT_ADD, 4'd0);
  endtask

  // kill every slot, current one included: ticks find nothing ready
  task automatic test_kill_all();
    for (int i = 0; i < MAX_TASKS; i++) send_beat(rrts_pkg::ACT_KILL, 4'(i));
    send_beat(rrts_pkg::ACT_TICK, 4'd5);
    send_beat(rrts_pkg::ACT_TICK, 4'd10);
    send_beat(rrts_pkg::ACT_QUERY, 4'd15);
  endtask

  initial begin
    // predicted state after reset: slot 0 ready and current
    foreach (slot_tbl[i]) slot_tbl[i] = rrts_pkg::ST_EMPTY;
    slot_tbl[0] = rrts_pkg::ST_READY;
    cur_slot    = 4'd0;
    free_id     = 5'd1;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_lone_task();
    test_rotation();
    test_random_traffic(1700);
    test_drain_pause();
    test_table_full();
    test_kill_all();

    // let the last beats out, then watch a while for anything extra
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_cnt == 0)
      $display("round_robin_task_scheduler_top_tb OK");
    else
      $display("round_robin_task_scheduler_top_tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
